@@ hdl/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RFD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rfd assertion failed");
`define RFD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("rfd assertion failed");
`else
`define RFD_ASSERT(label, clk, rst_n, prop)
`define RFD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ hdl/rfd_pkg.sv @@
// types and constants of the request frame deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

  localparam logic [31:0] REQ_MAGIC     = 32'h4454_434E;
  localparam logic [3:0]  HDR_LAST      = 4'd15;
  localparam logic [3:0]  SUM_HDR_BYTES = 4'd12;

  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [19:0] MAX_LEN_RESET = 20'd4096;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROTOCOL_VERSION   = 4'd0,
    CFG_MAX_PAYLOAD_LENGTH = 4'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PROTO  = 2'd1,
    ST_LENGTH = 2'd2,
    ST_LINK   = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  command;
    logic [15:0] case_number;
    logic [31:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/rfd_in_if.sv @@
// input byte channel of the request frame deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_error;

  modport source (output valid, output rx_byte, output link_error, input ready);
  modport sink   (input valid, input rx_byte, input link_error, output ready);
endinterface

`default_nettype wire

@@ hdl/rfd_out_if.sv @@
// result channel of the request frame deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [1:0]  status;
  logic [7:0]  command;
  logic [15:0] case_number;
  logic [31:0] payload_length;

  modport source (output valid, output kind, output payload_byte, output status,
                  output command, output case_number, output payload_length,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  input command, input case_number, input payload_length,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/rfd_cfg_if.sv @@
// configuration write channel of the request frame deframer
// depends on rfd_pkg for the index and data widths
`timescale 1ns / 1ps
`default_nettype none

interface rfd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rfd_pkg::CFG_IDX_W-1:0]  index;
  logic [rfd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/request_frame_deframer.sv @@
// request frame deframer: header parse, payload pass-through, checksum verdict
// depends on rfd_pkg, rfd_in_if, rfd_out_if, rfd_cfg_if and assert_macros.svh
// each result is registered in out_r, or in the skid entry while out_port stalls, from the byte beat that causes it
// throughput: one byte beat per cycle while in_port.ready is high; all per-byte work sits
//   between the frame state registers and a two-entry output stage (output register plus skid)
// in_port.ready drops only while the skid entry is occupied
// reset (rst_n low, synchronous) clears frame state and output stage and sets
//   protocol_version to 1 and max_payload_length to 4096
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module request_frame_deframer (
  input  wire        clk,
  input  wire        rst_n,
  rfd_in_if.sink     in_port,
  rfd_out_if.source  out_port,
  rfd_cfg_if.sink    cfg_port
);
  import rfd_pkg::*;

  logic [7:0]  version_r;
  logic [19:0] max_len_r;

  logic        in_payload_r, in_payload_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [19:0] pay_cnt_r, pay_cnt_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [7:0]  hver_r, hver_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [15:0] case_r, case_nxt;
  logic [31:0] length_r, length_nxt;
  logic [31:0] expected_r, expected_nxt;
  logic [31:0] sum_r, sum_nxt;

  result_t     out_r, skid_r, res;
  logic        out_valid_r, skid_valid_r, res_valid;

  logic        in_acc, out_acc;
  logic [7:0]  b;
  logic [31:0] sum_inc;
  logic [19:0] cnt_inc;
  logic [31:0] expected_full;
  logic        clear;

  assign in_acc  = in_port.valid && in_port.ready;
  assign out_acc = out_valid_r && out_port.ready;
  assign b       = in_port.rx_byte;
  assign sum_inc = sum_r + {24'd0, b};
  assign cnt_inc = pay_cnt_r + 20'd1;
  assign expected_full = {b, expected_r[23:0]};

  // configuration
  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VERSION_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_port.valid) begin
      case (cfg_port.index)
        CFG_PROTOCOL_VERSION:   version_r <= cfg_port.data[7:0];
        CFG_MAX_PAYLOAD_LENGTH: max_len_r <= cfg_port.data[19:0];
        default: ;
      endcase
    end
  end

  // per-byte frame update
  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_idx_nxt    = hdr_idx_r;
    pay_cnt_nxt    = pay_cnt_r;
    magic_nxt      = magic_r;
    hver_nxt       = hver_r;
    command_nxt    = command_r;
    case_nxt       = case_r;
    length_nxt     = length_r;
    expected_nxt   = expected_r;
    sum_nxt        = sum_r;
    clear          = 1'b0;
    res_valid      = 1'b0;
    res.kind           = KIND_VERDICT;
    res.payload_byte   = 8'd0;
    res.status         = ST_OK;
    res.command        = command_r;
    res.case_number    = case_r;
    res.payload_length = length_r;

    if (in_acc) begin
      if (in_port.link_error) begin
        res_valid  = 1'b1;
        res.status = ST_LINK;
        clear      = 1'b1;
      end else if (!in_payload_r) begin
        if (hdr_idx_r < SUM_HDR_BYTES) begin
          sum_nxt = sum_inc;
        end
        case (hdr_idx_r) inside
          [4'd0:4'd3]:   magic_nxt[8*hdr_idx_r[1:0] +: 8] = b;
          4'd4:          hver_nxt = b;
          4'd5:          command_nxt = b;
          [4'd6:4'd7]:   case_nxt[8*hdr_idx_r[0] +: 8] = b;
          [4'd8:4'd11]:  length_nxt[8*hdr_idx_r[1:0] +: 8] = b;
          default:       expected_nxt[8*hdr_idx_r[1:0] +: 8] = b;
        endcase
        if (hdr_idx_r != HDR_LAST) begin
          hdr_idx_nxt = hdr_idx_r + 4'd1;
        end else if (magic_r != REQ_MAGIC || hver_r != version_r) begin
          res_valid  = 1'b1;
          res.status = ST_PROTO;
          clear      = 1'b1;
        end else if (length_r > {12'd0, max_len_r}) begin
          res_valid  = 1'b1;
          res.status = ST_LENGTH;
          clear      = 1'b1;
        end else if (length_r == 32'd0) begin
          res_valid  = 1'b1;
          res.status = (sum_r == expected_full) ? ST_OK : ST_PROTO;
          clear      = 1'b1;
        end else begin
          in_payload_nxt = 1'b1;
          hdr_idx_nxt    = 4'd0;
          pay_cnt_nxt    = 20'd0;
        end
      end else begin
        sum_nxt          = sum_inc;
        pay_cnt_nxt      = cnt_inc;
        res_valid        = 1'b1;
        res.payload_byte = b;
        if ({12'd0, cnt_inc} == length_r) begin
          res.status = (sum_inc == expected_r) ? ST_OK : ST_PROTO;
          clear      = 1'b1;
        end else begin
          res.kind = KIND_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      in_payload_r <= 1'b0;
      hdr_idx_r    <= '0;
      pay_cnt_r    <= '0;
      magic_r      <= '0;
      hver_r       <= '0;
      command_r    <= '0;
      case_r       <= '0;
      length_r     <= '0;
      expected_r   <= '0;
      sum_r        <= '0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      pay_cnt_r    <= pay_cnt_nxt;
      magic_r      <= magic_nxt;
      hver_r       <= hver_nxt;
      command_r    <= command_nxt;
      case_r       <= case_nxt;
      length_r     <= length_nxt;
      expected_r   <= expected_nxt;
      sum_r        <= sum_nxt;
    end
  end

  // output register with skid entry
  assign in_port.ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_port.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_port.ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_port.valid          = out_valid_r;
  assign out_port.kind           = out_r.kind;
  assign out_port.payload_byte   = out_r.payload_byte;
  assign out_port.status         = out_r.status;
  assign out_port.command        = out_r.command;
  assign out_port.case_number    = out_r.case_number;
  assign out_port.payload_length = out_r.payload_length;

  `RFD_ASSERT(a_skid_needs_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `RFD_ASSERT(a_payload_idx_zero, clk, rst_n, in_payload_r |-> hdr_idx_r == 4'd0)
  `RFD_ASSERT(a_count_below_len, clk, rst_n, in_payload_r |-> 32'(pay_cnt_r) < length_r)
  `RFD_ASSERT(a_link_err_result, clk, rst_n, (in_acc && in_port.link_error) |=> out_valid_r)
  `RFD_ASSERT(a_drop_only_full, clk, rst_n, (out_acc && !skid_valid_r && !res_valid) |=> !out_valid_r)

endmodule

`default_nettype wire

@@ tb/tb_request_frame_deframer.sv @@
// testbench of request_frame_deframer: directed frames, then random frame traffic
// under sender gaps and receiver stalls, each result beat checked against a predictor
// depends on rfd_pkg, rfd_in_if, rfd_out_if, rfd_cfg_if and request_frame_deframer
`timescale 1ns / 1ps

module tb_request_frame_deframer;
  import rfd_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 500;

  logic clk;
  logic rst_n;

  rfd_in_if  in_port();
  rfd_out_if out_port();
  rfd_cfg_if cfg_port();

  request_frame_deframer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_port),
    .out_port (out_port),
    .cfg_port (cfg_port)
  );

  // predictor state
  logic        fr_in_payload;
  logic [3:0]  fr_hdr_idx;
  logic [19:0] fr_pay_count;
  logic [31:0] fr_magic;
  logic [7:0]  fr_version;
  logic [7:0]  fr_command;
  logic [15:0] fr_case;
  logic [31:0] fr_length;
  logic [31:0] fr_expected_sum;
  logic [31:0] fr_running_sum;
  logic [7:0]  model_version;
  logic [19:0] model_max_len;

  result_t frame_results_q[$];
  int      mismatch_count = 0;
  int      bytes_sent = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      quiet_cycles;

  // settings the stimulus aims at
  logic [7:0]  cur_version = VERSION_RESET;
  logic [19:0] cur_max_len = MAX_LEN_RESET;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_frame_model();
    fr_in_payload   = 1'b0;
    fr_hdr_idx      = '0;
    fr_pay_count    = '0;
    fr_magic        = '0;
    fr_version      = '0;
    fr_command      = '0;
    fr_case         = '0;
    fr_length       = '0;
    fr_expected_sum = '0;
    fr_running_sum  = '0;
  endfunction

  function automatic void post_result(kind_t k, logic [7:0] b, status_t s);
    result_t r;
    r.kind           = k;
    r.payload_byte   = b;
    r.status         = s;
    r.command        = fr_command;
    r.case_number    = fr_case;
    r.payload_length = fr_length;
    frame_results_q.push_back(r);
  endfunction

  function automatic void post_verdict(logic [7:0] b, status_t s);
    post_result(KIND_VERDICT, b, s);
    clear_frame_model();
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic err);
    int      idx;
    status_t sum_status;
    idx = int'(fr_hdr_idx);
    sum_status = (fr_running_sum + b == fr_expected_sum) ? ST_OK : ST_PROTO;
    if (err) begin
      post_verdict(8'h00, ST_LINK);
    end else if (!fr_in_payload) begin
      if (idx < SUM_HDR_BYTES) fr_running_sum += b;
      if (idx < 4) fr_magic[8*idx +: 8] = b;
      else if (idx == 4) fr_version = b;
      else if (idx == 5) fr_command = b;
      else if (idx < 8) fr_case[8*(idx-6) +: 8] = b;
      else if (idx < 12) fr_length[8*(idx-8) +: 8] = b;
      else fr_expected_sum[8*(idx-12) +: 8] = b;
      if (idx < HDR_LAST) begin
        fr_hdr_idx = fr_hdr_idx + 4'd1;
      end else if (fr_magic != REQ_MAGIC || fr_version != model_version) begin
        post_verdict(8'h00, ST_PROTO);
      end else if (fr_length > {12'd0, model_max_len}) begin
        post_verdict(8'h00, ST_LENGTH);
      end else if (fr_length == 32'd0) begin
        post_verdict(8'h00, (fr_running_sum == fr_expected_sum) ? ST_OK : ST_PROTO);
      end else begin
        fr_hdr_idx    = '0;
        fr_in_payload = 1'b1;
        fr_pay_count  = '0;
      end
    end else begin
      fr_running_sum += b;
      fr_pay_count = fr_pay_count + 20'd1;
      if ({12'd0, fr_pay_count} == fr_length) begin
        post_verdict(b, sum_status);
      end else begin
        post_result(KIND_PAYLOAD, b, ST_OK);
      end
    end
  endfunction

  task automatic check_result_beat();
    result_t want;
    if (frame_results_q.size() == 0) begin
      $error("unexpected result beat: kind %0d status %0d", out_port.kind, out_port.status);
      mismatch_count++;
    end else begin
      want = frame_results_q.pop_front();
      if (out_port.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, out_port.kind);
        mismatch_count++;
      end
      if (out_port.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, out_port.payload_byte);
        mismatch_count++;
      end
      if (out_port.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_port.status);
        mismatch_count++;
      end
      if (out_port.command !== want.command) begin
        $error("command: expected %0h, got %0h", want.command, out_port.command);
        mismatch_count++;
      end
      if (out_port.case_number !== want.case_number) begin
        $error("case_number: expected %0h, got %0h", want.case_number, out_port.case_number);
        mismatch_count++;
      end
      if (out_port.payload_length !== want.payload_length) begin
        $error("payload_length: expected %0h, got %0h",
               want.payload_length, out_port.payload_length);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame_model();
      model_version = VERSION_RESET;
      model_max_len = MAX_LEN_RESET;
      frame_results_q.delete();
    end else begin
      if (out_port.valid && out_port.ready) check_result_beat();
      if (cfg_port.valid && cfg_port.ready) begin
        case (cfg_port.index)
          CFG_PROTOCOL_VERSION:   model_version = cfg_port.data[7:0];
          CFG_MAX_PAYLOAD_LENGTH: model_max_len = cfg_port.data[19:0];
          default: ;
        endcase
      end
      if (in_port.valid && in_port.ready) deframe_byte(in_port.rx_byte, in_port.link_error);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_port.valid && in_port.ready) || (out_port.valid && out_port.ready)
        || (cfg_port.valid && cfg_port.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    out_port.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_port.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic err);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_port.valid = 1'b0;
      @(negedge clk);
    end
    in_port.valid      = 1'b1;
    in_port.rx_byte    = b;
    in_port.link_error = err;
    @(posedge clk);
    while (!in_port.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drained(input int extra);
    @(negedge clk);
    in_port.valid = 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    wait_drained(SETTLE_CYCLES);
    cfg_port.valid = 1'b1;
    cfg_port.index = idx;
    cfg_port.data  = value;
    @(posedge clk);
    while (!cfg_port.ready) @(posedge clk);
    @(negedge clk);
    cfg_port.valid = 1'b0;
    if (idx == CFG_PROTOCOL_VERSION) cur_version = value[7:0];
    else cur_max_len = value[19:0];
  endtask

  // abort_at < 0 sends all; else a link error replaces byte abort_at, if in the frame
  task automatic send_frame(input logic [31:0] magic, input logic [7:0] version,
                            input logic [7:0] cmd, input logic [15:0] case_id,
                            input logic [31:0] len, input logic [31:0] sum_flip,
                            input int abort_at);
    logic [7:0]  hdr[16];
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [31:0] chk;
    int          n;
    n = (magic == REQ_MAGIC && version == cur_version && len <= {12'd0, cur_max_len})
        ? int'(len) : 0;
    for (int k = 0; k < 4; k++) begin
      hdr[k]     = magic[8*k +: 8];
      hdr[8 + k] = len[8*k +: 8];
    end
    hdr[4] = version;
    hdr[5] = cmd;
    hdr[6] = case_id[7:0];
    hdr[7] = case_id[15:8];
    chk = '0;
    for (int k = 0; k < 12; k++) chk += hdr[k];
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom);
      body.push_back(b);
      chk += b;
    end
    chk ^= sum_flip;
    for (int k = 0; k < 4; k++) hdr[12 + k] = chk[8*k +: 8];
    for (int k = 0; k < 16 + n; k++) begin
      if (k == abort_at) begin
        send_beat(8'($urandom), 1'b1);
        break;
      end
      send_beat((k < 16) ? hdr[k] : body[k-16], 1'b0);
    end
  endtask

  task automatic test_link_error_idle();
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b1);
  endtask

  task automatic test_frame_extremes();
    send_frame(REQ_MAGIC, cur_version, 8'h00, 16'h0000, 32'd0, 32'd0, -1);
    send_frame(REQ_MAGIC, cur_version, 8'hFF, 16'hFFFF, 32'd1, 32'd0, -1);
    send_frame(REQ_MAGIC, cur_version, 8'h5A, 16'h1234, 32'd3, 32'h8000_0000, -1);
    send_frame(REQ_MAGIC, cur_version, 8'hA5, 16'h8001, 32'd0, 32'h0000_0001, -1);
  endtask

  task automatic test_header_errors();
    send_frame(REQ_MAGIC ^ 32'h1, cur_version, 8'h11, 16'h0011, 32'd2, 32'd0, -1);
    send_frame(REQ_MAGIC, cur_version + 8'd1, 8'h22, 16'h0022, 32'd2, 32'd0, -1);
    send_frame(32'h0, 8'h00, 8'h33, 16'h0033, 32'hFFFF_FFFF, 32'd0, -1);
  endtask

  task automatic test_length_limit();
    write_reg(CFG_MAX_PAYLOAD_LENGTH, 32'd8);
    send_frame(REQ_MAGIC, cur_version, 8'h44, 16'h0044, 32'd8, 32'd0, -1);
    send_frame(REQ_MAGIC, cur_version, 8'h45, 16'h0045, 32'd9, 32'd0, -1);
    send_frame(REQ_MAGIC, cur_version, 8'h46, 16'h0046, 32'hFFFF_FFFF, 32'd0, -1);
  endtask

  task automatic test_link_abort();
    send_frame(REQ_MAGIC, cur_version, 8'h55, 16'h0055, 32'd4, 32'd0, 5);
    send_frame(REQ_MAGIC, cur_version, 8'h56, 16'h0056, 32'd4, 32'd0, 18);
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_PROTOCOL_VERSION, 32'd0);
    send_frame(REQ_MAGIC, 8'h00, 8'h61, 16'h0061, 32'd2, 32'd0, -1);
    write_reg(CFG_PROTOCOL_VERSION, 32'd255);
    send_frame(REQ_MAGIC, 8'hFF, 8'h62, 16'h0062, 32'd2, 32'd0, -1);
    send_frame(REQ_MAGIC, 8'h00, 8'h63, 16'h0063, 32'd2, 32'd0, -1);
    write_reg(CFG_MAX_PAYLOAD_LENGTH, 32'd0);
    send_frame(REQ_MAGIC, 8'hFF, 8'h64, 16'h0064, 32'd0, 32'd0, -1);
    send_frame(REQ_MAGIC, 8'hFF, 8'h65, 16'h0065, 32'd1, 32'd0, -1);
    write_reg(CFG_MAX_PAYLOAD_LENGTH, 32'd1048575);
    send_frame(REQ_MAGIC, 8'hFF, 8'h66, 16'h0066, 32'd1048576, 32'd0, -1);
    send_frame(REQ_MAGIC, 8'hFF, 8'h67, 16'h0067, 32'd5, 32'd0, -1);
    write_reg(CFG_PROTOCOL_VERSION, 32'(VERSION_RESET));
    write_reg(CFG_MAX_PAYLOAD_LENGTH, 32'(MAX_LEN_RESET));
  endtask

  task automatic send_noise();
    int n;
    n = int'($urandom_range(20, 1));
    for (int k = 0; k < n; k++) send_beat(8'($urandom), $urandom_range(9) == 0);
    if ($urandom_range(9) < 7) send_beat(8'($urandom), 1'b1);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    logic [31:0] magic;
    logic [7:0]  version;
    logic [31:0] len;
    logic [31:0] flip;
    int          abort_at;
    pick     = $urandom_range(99);
    magic    = REQ_MAGIC;
    version  = cur_version;
    flip     = '0;
    abort_at = -1;
    len      = $urandom_range(24);
    if (len > {12'd0, cur_max_len}) len = {12'd0, cur_max_len};
    if (pick < 8) begin
      magic ^= 32'h1 << $urandom_range(31);
    end else if (pick < 14) begin
      version ^= 8'h1 << $urandom_range(7);
    end else if (pick < 22) begin
      len = $urandom_range(1) ? {12'd0, cur_max_len} + 32'd1 + $urandom_range(1000)
                              : ($urandom | 32'h8000_0000);
    end else if (pick < 30) begin
      flip = 32'h1 << $urandom_range(31);
    end else if (pick < 40) begin
      abort_at = int'($urandom_range(16 + len));
    end
    if (pick >= 93) send_noise();
    else send_frame(magic, version, 8'($urandom), 16'($urandom), len, flip, abort_at);
  endtask

  task automatic test_random_traffic();
    int phase_start;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      write_reg(CFG_PROTOCOL_VERSION, $urandom_range(255));
      case ($urandom_range(9))
        0:       write_reg(CFG_MAX_PAYLOAD_LENGTH, 32'd0);
        1:       write_reg(CFG_MAX_PAYLOAD_LENGTH, 32'd1048575);
        2, 3:    write_reg(CFG_MAX_PAYLOAD_LENGTH, 32'(MAX_LEN_RESET));
        default: write_reg(CFG_MAX_PAYLOAD_LENGTH, $urandom_range(64, 1));
      endcase
      phase_start = bytes_sent;
      while (bytes_sent < phase_start + PHASE_BYTES) begin
        send_random_frame();
        if ($urandom_range(99) < 4) wait_drained(0);
      end
    end
  endtask

  initial begin
    in_port.valid      = 1'b0;
    in_port.rx_byte    = '0;
    in_port.link_error = 1'b0;
    cfg_port.valid     = 1'b0;
    cfg_port.index     = CFG_PROTOCOL_VERSION;
    cfg_port.data      = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_link_error_idle();
    test_frame_extremes();
    test_header_errors();
    test_length_limit();
    test_link_abort();
    test_config_extremes();
    test_random_traffic();

    wait_drained(SETTLE_CYCLES * 4);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
